// ===== hw/rtl/lmts_pkg.sv =====
// Shared types and constants for the LCD mode and scanline timing sequencer.
package lmts_pkg;

	localparam int DotW  = 11;
	localparam int LineW = 8;
	localparam int ElapW = 6;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 8;

	localparam logic [DotW-1:0] OAM_END  = 11'd80;
	localparam logic [DotW-1:0] XFER_END = 11'd252;
	localparam logic [DotW-1:0] DOT_MAX  = 11'd2047;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_XFER   = 2'd3
	} lmts_mode_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_DISPLAY_ENABLE = 2'd0,
		REG_STAT_IRQ_EN    = 2'd1,
		REG_LINE_COMPARE   = 2'd2,
		REG_UNUSED         = 2'd3
	} lmts_reg_t;

	localparam int STAT_HBLANK = 0;
	localparam int STAT_VBLANK = 1;
	localparam int STAT_OAM    = 2;
	localparam int STAT_LYC    = 3;

	typedef struct packed {
		logic             display_enable;
		logic [3:0]       stat_irq_enables;
		logic [LineW-1:0] line_compare;
	} lmts_cfg_t;

	typedef struct packed {
		lmts_mode_t       mode;
		logic [LineW-1:0] line;
		logic             coincidence;
		logic             vblank_irq;
		logic             stat_irq;
		logic             hblank_start;
		logic             frame_done;
	} lmts_result_t;

endpackage

// ===== hw/rtl/lcd_mode_timing_sequencer_top.sv =====
// Top level: config registers, input register, timing core and result register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  in       | in_valid / in_stall  | elapsed_cycles
//  out      | out_valid / out_stall| lcd_mode, current_line, coincidence, vblank_irq,
//           |                      | stat_irq, hblank_start, frame_done
//  config   | cfg_we               | cfg_index, cfg_wdata
//
// One transaction per cycle while out_stall is low; the result is valid once the
// input has passed the input register, then the result register. The step logic
// between them is a saturating 11-bit add, a line increment, subtracts and compares.
// Reset puts the sequencer in OAM search on line 0 with the display enabled.
// A stall on the output holds the result register; the input register holds
// one more transaction, after which in_stall rises.
module lcd_mode_timing_sequencer_top #(
	parameter int VISIBLE_LINES = 144,
	parameter int TOTAL_LINES   = 154,
	parameter int LINE_CYCLES   = 456
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lmts_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [lmts_pkg::CfgDataW-1:0]  cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [lmts_pkg::ElapW-1:0]     elapsed_cycles,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     lcd_mode,
	output logic [lmts_pkg::LineW-1:0]     current_line,
	output logic                           coincidence,
	output logic                           vblank_irq,
	output logic                           stat_irq,
	output logic                           hblank_start,
	output logic                           frame_done
);
	import lmts_pkg::*;

	lmts_cfg_t        cfg_q;
	logic             valid_s1;
	logic [ElapW-1:0] elapsed_s1;
	logic             valid_s2;
	lmts_result_t     result_s2;
	lmts_result_t     step_result;
	logic             s2_free;
	logic             advance;
	logic             in_accept;

	assign s2_free   = !valid_s2 || !out_stall;
	assign advance   = valid_s1 && s2_free;
	assign in_stall  = valid_s1 && !s2_free;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.display_enable   <= 1'b1;
			cfg_q.stat_irq_enables <= '0;
			cfg_q.line_compare     <= '0;
		end else if (cfg_we) begin
			unique case (lmts_reg_t'(cfg_index))
				REG_DISPLAY_ENABLE: cfg_q.display_enable   <= cfg_wdata[0];
				REG_STAT_IRQ_EN:    cfg_q.stat_irq_enables <= cfg_wdata[3:0];
				REG_LINE_COMPARE:   cfg_q.line_compare     <= cfg_wdata;
				REG_UNUSED:         ;
				default:            ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_accept)
			elapsed_s1 <= elapsed_cycles;
	end

	lmts_core #(
		.VISIBLE_LINES(VISIBLE_LINES),
		.TOTAL_LINES  (TOTAL_LINES),
		.LINE_CYCLES  (LINE_CYCLES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(advance),
		.elapsed(elapsed_s1),
		.cfg    (cfg_q),
		.result (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (s2_free)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_s2 <= step_result;
	end

	assign out_valid    = valid_s2;
	assign lcd_mode     = result_s2.mode;
	assign current_line = result_s2.line;
	assign coincidence  = result_s2.coincidence;
	assign vblank_irq   = result_s2.vblank_irq;
	assign stat_irq     = result_s2.stat_irq;
	assign hblank_start = result_s2.hblank_start;
	assign frame_done   = result_s2.frame_done;

endmodule

// ===== hw/rtl/lmts_core.sv =====
// Timing state registers and the single-step mode/line transition logic.
module lmts_core #(
	parameter int VISIBLE_LINES = 144,
	parameter int TOTAL_LINES   = 154,
	parameter int LINE_CYCLES   = 456
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step_en,
	input  logic [lmts_pkg::ElapW-1:0] elapsed,
	input  lmts_pkg::lmts_cfg_t       cfg,
	output lmts_pkg::lmts_result_t    result
);
	import lmts_pkg::*;

	localparam logic [LineW:0]  VIS_N   = (LineW+1)'(VISIBLE_LINES);
	localparam logic [LineW:0]  TOTAL_N = (LineW+1)'(TOTAL_LINES);
	localparam logic [DotW-1:0] LINE_N  = DotW'(LINE_CYCLES);

	logic [DotW-1:0]  dot_q, dot_d, dot_sat;
	logic [DotW:0]    dot_sum;
	lmts_mode_t       mode_q, mode_d;
	logic [LineW-1:0] line_q, line_d;
	logic             coin_q, coin_d;
	logic [LineW:0]   line_inc;
	logic             stat_d, vbl_d, hbl_d, frame_d;

	assign dot_sum  = {1'b0, dot_q} + (DotW+1)'(elapsed);
	assign dot_sat  = dot_sum[DotW] ? DOT_MAX : dot_sum[DotW-1:0];
	assign line_inc = {1'b0, line_q} + (LineW+1)'(1);

	always_comb begin
		dot_d   = dot_q;
		mode_d  = mode_q;
		line_d  = line_q;
		coin_d  = coin_q;
		stat_d  = 1'b0;
		vbl_d   = 1'b0;
		hbl_d   = 1'b0;
		frame_d = 1'b0;
		if (!cfg.display_enable) begin
			mode_d = MODE_VBLANK;
			line_d = '0;
		end else begin
			dot_d = dot_sat;
			unique case (mode_q)
				MODE_OAM: begin
					if (dot_sat >= OAM_END)
						mode_d = MODE_XFER;
				end
				MODE_XFER: begin
					if (dot_sat >= XFER_END) begin
						mode_d = MODE_HBLANK;
						hbl_d  = 1'b1;
						stat_d = cfg.stat_irq_enables[STAT_HBLANK];
					end
				end
				MODE_HBLANK: begin
					if (dot_sat >= LINE_N) begin
						dot_d  = dot_sat - LINE_N;
						line_d = line_inc[LineW-1:0];
						if (line_inc == VIS_N) begin
							mode_d  = MODE_VBLANK;
							vbl_d   = 1'b1;
							frame_d = 1'b1;
							stat_d  = cfg.stat_irq_enables[STAT_VBLANK];
						end else begin
							mode_d = MODE_OAM;
							stat_d = cfg.stat_irq_enables[STAT_OAM];
						end
					end
				end
				MODE_VBLANK: begin
					if (dot_sat >= LINE_N) begin
						dot_d = dot_sat - LINE_N;
						if (line_inc >= TOTAL_N) begin
							mode_d = MODE_OAM;
							line_d = '0;
							stat_d = cfg.stat_irq_enables[STAT_OAM];
						end else begin
							line_d = line_inc[LineW-1:0];
						end
					end
				end
				default: ;
			endcase
			coin_d = (line_d == cfg.line_compare);
			if (coin_d && cfg.stat_irq_enables[STAT_LYC])
				stat_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q  <= '0;
			mode_q <= MODE_OAM;
			line_q <= '0;
			coin_q <= 1'b0;
		end else if (step_en) begin
			dot_q  <= dot_d;
			mode_q <= mode_d;
			line_q <= line_d;
			coin_q <= coin_d;
		end
	end

	always_comb begin
		result.mode         = mode_d;
		result.line         = line_d;
		result.coincidence  = coin_d;
		result.vblank_irq   = vbl_d;
		result.stat_irq     = stat_d;
		result.hblank_start = hbl_d;
		result.frame_done   = frame_d;
	end

endmodule
